### sv/bsdq_pkg.sv
// bsdq_pkg: shared constants, codes and item types for the buffer slot deque
// used by every module of the block; depends on nothing
`default_nettype none

package bsdq_pkg;

  // pool size and derived widths
  localparam int SLOTS  = 8;
  localparam int SLOT_W = 3;
  localparam int PTR_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [SUM_W-1:0] SLOTS_SUM = SUM_W'(SLOTS);

  // action codes of an input item
  typedef enum logic [1:0] {
    ACT_PROD_OBTAIN = 2'd0,
    ACT_PROD_SUBMIT = 2'd1,
    ACT_CONS_OBTAIN = 2'd2,
    ACT_CONS_SUBMIT = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    status_t           status;
  } out_item_t;

  // list bookkeeping exported from the core for checking
  typedef struct packed {
    logic [CNT_W-1:0] held_count;
    logic [SLOTS-1:0] marks;
  } bsdq_stat_t;

  // fold a sum below twice the pool size back into a ring index
  function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = (v >= SLOTS_SUM) ? (v - SLOTS_SUM) : v;
    return r[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/bsdq_in_stage.sv
// bsdq_in_stage: input register of the deque, holds one accepted item
// depends on bsdq_pkg for the item type
`default_nettype none

module bsdq_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bsdq_pkg::in_item_t in_item,
  input  wire logic              advance,
  output logic                   s1_valid,
  output bsdq_pkg::in_item_t     s1_item
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  bsdq_pkg::in_item_t s1_item_r;

  // the register frees up when its item moves on this cycle
  assign in_stall = s1_valid_r & ~advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

### sv/bsdq_core.sv
// bsdq_core: slot ring, top pointer, fill count and in-list marks; computes
// the result of one action and commits the update when the item moves on
// depends on bsdq_pkg
`default_nettype none

module bsdq_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire bsdq_pkg::in_item_t item,
  output bsdq_pkg::out_item_t     result,
  output bsdq_pkg::bsdq_stat_t    stat
);

  logic [bsdq_pkg::SLOT_W-1:0] ring_r [bsdq_pkg::SLOTS];
  logic [bsdq_pkg::PTR_W-1:0]  top_r;
  logic [bsdq_pkg::PTR_W-1:0]  top_nxt;
  logic [bsdq_pkg::CNT_W-1:0]  count_r;
  logic [bsdq_pkg::CNT_W-1:0]  count_nxt;
  logic [bsdq_pkg::SLOTS-1:0]  marks_r;
  logic [bsdq_pkg::SLOTS-1:0]  marks_nxt;

  logic                        ring_we;
  logic [bsdq_pkg::PTR_W-1:0]  ring_wa;
  logic [bsdq_pkg::PTR_W-1:0]  bottom_pos;
  logic [bsdq_pkg::PTR_W-1:0]  below_pos;
  logic [bsdq_pkg::PTR_W-1:0]  above_top;
  logic [bsdq_pkg::PTR_W-1:0]  next_top;
  logic [bsdq_pkg::PTR_W-1:0]  slot_idx;
  logic                        slot_bad;
  logic [bsdq_pkg::SLOT_W-1:0] got;
  logic [bsdq_pkg::PTR_W-1:0]  got_idx;

  // ring positions around the current list
  assign bottom_pos = bsdq_pkg::ring_wrap(bsdq_pkg::SUM_W'(top_r) +
                                          bsdq_pkg::SUM_W'(count_r) -
                                          bsdq_pkg::SUM_W'(1));
  assign below_pos  = bsdq_pkg::ring_wrap(bsdq_pkg::SUM_W'(top_r) +
                                          bsdq_pkg::SUM_W'(count_r));
  assign next_top   = bsdq_pkg::ring_wrap(bsdq_pkg::SUM_W'(top_r) +
                                          bsdq_pkg::SUM_W'(1));
  assign above_top  = (top_r == '0) ? bsdq_pkg::PTR_W'(bsdq_pkg::SLOTS - 1)
                                    : (top_r - bsdq_pkg::PTR_W'(1));

  assign slot_idx = bsdq_pkg::PTR_W'(item.slot_in);
  assign slot_bad = (bsdq_pkg::SUM_W'(item.slot_in) >= bsdq_pkg::SLOTS_SUM) ||
                    marks_r[slot_idx] || (count_r >= bsdq_pkg::SLOTS_CNT);

  // action decode and next state
  always_comb begin
    top_nxt         = top_r;
    count_nxt       = count_r;
    marks_nxt       = marks_r;
    ring_we         = 1'b0;
    ring_wa         = below_pos;
    got             = '0;
    got_idx         = '0;
    result.slot_out = '0;
    result.status   = bsdq_pkg::ST_DONE;
    unique case (item.action)
      bsdq_pkg::ACT_PROD_OBTAIN,
      bsdq_pkg::ACT_CONS_OBTAIN: begin
        if (count_r == '0) begin
          result.status = bsdq_pkg::ST_EMPTY;
        end else begin
          if (item.action == bsdq_pkg::ACT_PROD_OBTAIN) begin
            got = ring_r[bottom_pos];
          end else begin
            got     = ring_r[top_r];
            top_nxt = next_top;
          end
          got_idx            = bsdq_pkg::PTR_W'(got);
          result.slot_out    = got;
          count_nxt          = count_r - bsdq_pkg::CNT_W'(1);
          marks_nxt[got_idx] = 1'b0;
        end
      end
      bsdq_pkg::ACT_PROD_SUBMIT,
      bsdq_pkg::ACT_CONS_SUBMIT: begin
        if (slot_bad) begin
          result.status = bsdq_pkg::ST_REFUSED;
        end else begin
          ring_we = 1'b1;
          if (item.action == bsdq_pkg::ACT_PROD_SUBMIT) begin
            top_nxt = above_top;
            ring_wa = above_top;
          end
          count_nxt           = count_r + bsdq_pkg::CNT_W'(1);
          marks_nxt[slot_idx] = 1'b1;
        end
      end
      default: begin
        result.status = bsdq_pkg::ST_DONE;
      end
    endcase
  end

  // pointers, count and marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= '0;
      count_r <= bsdq_pkg::SLOTS_CNT;
      marks_r <= '1;
    end else if (fire) begin
      top_r   <= top_nxt;
      count_r <= count_nxt;
      marks_r <= marks_nxt;
    end
  end

  // slot ring, one entry written per accepted submit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bsdq_pkg::SLOTS; i++) begin
        ring_r[i] <= bsdq_pkg::SLOT_W'(i);
      end
    end else if (fire && ring_we) begin
      ring_r[ring_wa] <= item.slot_in;
    end
  end

  assign stat.held_count = count_r;
  assign stat.marks      = marks_r;

endmodule

`default_nettype wire

### sv/buffer_slot_deque_top.sv
// buffer_slot_deque_top: top level of the buffer slot deque, input stage,
// core and result register; depends on bsdq_pkg, bsdq_in_stage, bsdq_core
`default_nettype none

// Buffer slot deque. Keeps the free slots of an 8-slot pool in one ordered
// list; after reset all slots are in it with slot 0 on top. Each input item
// is one action (producer obtain from bottom, producer submit to top,
// consumer obtain from top, consumer submit to bottom) and yields exactly
// one result: a slot number and a status. An obtain on an empty list, and a
// submit of a slot already in the list, are refused and leave the list as
// it was. Without a stall at the output one item is taken every clock cycle.
// An accepted item is held in the input register, the list update is done
// while it sits there and is committed as the item moves on, and its result
// is then held in the result register until it is taken. A stalled result
// holds the input register, which then stalls the input.

module buffer_slot_deque_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bsdq_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bsdq_pkg::out_item_t      out_item
);

  logic                 s1_valid;
  bsdq_pkg::in_item_t   s1_item;
  logic                 advance;
  bsdq_pkg::out_item_t  result;
  bsdq_pkg::bsdq_stat_t stat;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  bsdq_pkg::out_item_t  out_item_r;

  // an item moves into the result register when it is empty or being taken
  assign advance = s1_valid & (~out_valid_r | ~out_stall);

  bsdq_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bsdq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item),
    .result (result),
    .stat   (stat)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  // list never holds more than the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.held_count <= bsdq_pkg::SLOTS_CNT)
    else $error("held count above pool size");

  // marks agree with the fill count
  a_marks_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(stat.marks) == int'(stat.held_count))
    else $error("in-list marks disagree with held count");

  // a refused obtain hands out nothing
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == bsdq_pkg::ST_EMPTY) |-> out_item.slot_out == '0)
    else $error("empty result carries a slot");

  // an obtain that completes shrinks the list by one
  a_obtain_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.status == bsdq_pkg::ST_DONE &&
     (s1_item.action == bsdq_pkg::ACT_PROD_OBTAIN ||
      s1_item.action == bsdq_pkg::ACT_CONS_OBTAIN))
    |=> stat.held_count == $past(stat.held_count) - bsdq_pkg::CNT_W'(1))
    else $error("obtain did not shrink the list");
`endif

endmodule

`default_nettype wire
